// ----- design/assert_macros.svh -----
// Assertion macros for the checker file of the block, awa_chk.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge, skipped while reset is asserted.
`define AWA_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("access window check failed");

// Check a property on every rising edge, reset included.
`define AWA_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("access window reset check failed");

`endif

// ----- design/awa_pkg.sv -----
// Package of the access window authenticator: constants, entry and command types.
// No dependencies; imported by awa_ctrl, awa_dp, the top level and the testbench.
package awa_pkg;

    localparam int DEF_MAX_ENTRIES = 32;
    localparam int SEC_PER_DAY     = 60 * 60 * 24;
    localparam int SEC_PER_HOUR    = 60 * 60;
    localparam int SEC_PER_MIN     = 60;
    localparam int TOD_W           = 17;
    localparam int TS_W            = 32;
    localparam int CNT_W           = 6;
    localparam int SLOT_W          = 5;
    // One day is 675 << 7 seconds. Dividing the timestamp shifted down by 7 by 675
    // is exact for every 25-bit value with the rounded-up reciprocal 2**35 / 675.
    localparam int DAY_SHIFT       = 7;
    localparam int DAY_RECIP       = 50903317;
    localparam int RECIP_W         = 26;
    localparam int RECIP_SHIFT     = 35;
    localparam int PROD_W          = TS_W - DAY_SHIFT + RECIP_W;
    localparam int QUO_W           = PROD_W - RECIP_SHIFT;
    // Multiply, multiply back, subtract.
    localparam int MOD_STEPS       = 3;
    localparam int STEP_W          = $clog2(MOD_STEPS);

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef struct packed {
        logic [15:0]      uid_high;
        logic [63:0]      uid_low;
        logic [TOD_W-1:0] win_begin;
        logic [TOD_W-1:0] win_end;
    } t_entry;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MOD,
        S_SCAN,
        S_FLUSH,
        S_DONE
    } t_state;

    typedef struct packed {
        logic start;
        logic mod_step;
        logic scan_step;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic mod_last;
        logic scan_empty;
        logic scan_last;
    } t_dp_sts;

endpackage

// ----- design/awa_ctrl.sv -----
// Controller of the access window authenticator: sequences load, reduction and scan.
// Depends on awa_pkg.
module awa_ctrl
    import awa_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_opcode,
    input  logic    i_out_stall,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd,
    output logic    o_in_stall,
    output logic    o_out_valid
);

    t_state r_state, n_state;
    logic   r_out_vld, n_out_vld;
    logic   w_accept;
    logic   w_out_free;

    assign w_accept   = i_in_valid && (r_state == S_IDLE);
    assign w_out_free = !r_out_vld || !i_out_stall;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = (i_opcode == OP_QUERY) ? S_MOD : S_DONE;
                end
            end
            S_MOD: begin
                if (i_sts.mod_last) begin
                    n_state = i_sts.scan_empty ? S_DONE : S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_sts.scan_last) begin
                    n_state = S_FLUSH;
                end
            end
            S_FLUSH: n_state = S_DONE;
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd           = '0;
        o_cmd.start     = w_accept;
        o_cmd.mod_step  = (r_state == S_MOD);
        o_cmd.scan_step = (r_state == S_SCAN);
        o_cmd.load_out  = (r_state == S_DONE) && w_out_free;
    end

    always_comb begin
        n_out_vld = r_out_vld;
        if (o_cmd.load_out) begin
            n_out_vld = 1'b1;
        end else if (!i_out_stall) begin
            n_out_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_vld;

endmodule

// ----- design/awa_dp.sv -----
// Datapath of the access window authenticator: entry table, day reduction, match.
// Depends on awa_pkg; driven by awa_ctrl commands.
module awa_dp
    import awa_pkg::*;
#(
    parameter int MAX_ENTRIES = DEF_MAX_ENTRIES
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [CNT_W-1:0]  i_cfg_wdata,
    input  t_dp_cmd           i_cmd,
    input  logic              i_opcode,
    input  logic [SLOT_W-1:0] i_entry_index,
    input  logic [15:0]       i_uid_high,
    input  logic [63:0]       i_uid_low,
    input  logic [4:0]        i_begin_hour,
    input  logic [5:0]        i_begin_minute,
    input  logic [4:0]        i_end_hour,
    input  logic [5:0]        i_end_minute,
    input  logic [TS_W-1:0]   i_timestamp,
    output t_dp_sts           o_sts,
    output logic              o_granted
);

    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int LIM_W = ($clog2(MAX_ENTRIES + 1) > CNT_W) ?
                           $clog2(MAX_ENTRIES + 1) : CNT_W;

    t_entry             r_mem [MAX_ENTRIES];
    t_entry             r_rd;
    t_entry             w_wdata;
    logic               w_we;
    logic [CNT_W-1:0]   r_entry_count;
    logic [LIM_W-1:0]   w_limit;
    logic [15:0]        r_uid_high;
    logic [63:0]        r_uid_low;
    logic [TS_W-1:0]    r_ts;
    logic [PROD_W-1:0]  r_prod;
    logic [QUO_W-1:0]   w_quo;
    logic [TOD_W-1:0]   r_qd;
    logic [TOD_W-1:0]   r_rem;
    logic [STEP_W-1:0]  r_step;
    logic [IDX_W-1:0]   r_idx;
    logic               r_cmp_vld;
    logic               r_hit;
    logic               r_granted;
    logic [TOD_W-1:0]   w_tod;
    logic               w_match;

    // Entry written by a load beat.
    assign w_we = i_cmd.start && (i_opcode == OP_LOAD) &&
                  (LIM_W'(i_entry_index) < LIM_W'(MAX_ENTRIES));

    always_comb begin
        w_wdata           = '0;
        w_wdata.uid_high  = i_uid_high;
        w_wdata.uid_low   = i_uid_low;
        w_wdata.win_begin = TOD_W'(i_begin_hour) * TOD_W'(SEC_PER_HOUR) +
                            TOD_W'(i_begin_minute) * TOD_W'(SEC_PER_MIN);
        w_wdata.win_end   = TOD_W'(i_end_hour) * TOD_W'(SEC_PER_HOUR) +
                            TOD_W'(i_end_minute) * TOD_W'(SEC_PER_MIN);
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[IDX_W'(i_entry_index)] <= w_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_step) begin
            r_rd <= r_mem[r_idx];
        end
    end

    // Clamp the search length to the table size.
    assign w_limit = (LIM_W'(r_entry_count) > LIM_W'(MAX_ENTRIES)) ?
                     LIM_W'(MAX_ENTRIES) : LIM_W'(r_entry_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_count <= '0;
        end else if (i_cfg_we) begin
            r_entry_count <= i_cfg_wdata;
        end
    end

    // Reduce modulo one day in three register stages: quotient by reciprocal
    // multiplication, quotient times one day, then the difference. Only the low
    // bits of the last two are kept, as the time of day fits them.
    assign w_quo = r_prod[PROD_W-1:RECIP_SHIFT];

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_ts       <= i_timestamp;
            r_step     <= STEP_W'(MOD_STEPS - 1);
            r_uid_high <= i_uid_high;
            r_uid_low  <= i_uid_low;
        end else if (i_cmd.mod_step) begin
            r_prod <= PROD_W'(r_ts[TS_W-1:DAY_SHIFT]) * PROD_W'(DAY_RECIP);
            r_qd   <= TOD_W'(w_quo) * TOD_W'(SEC_PER_DAY);
            r_rem  <= r_ts[TOD_W-1:0] - r_qd;
            r_step <= r_step - STEP_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_idx <= '0;
        end else if (i_cmd.scan_step) begin
            r_idx <= r_idx + IDX_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmp_vld <= 1'b0;
        end else begin
            r_cmp_vld <= i_cmd.scan_step;
        end
    end

    assign w_tod   = r_rem;
    assign w_match = (r_rd.uid_high == r_uid_high) && (r_rd.uid_low == r_uid_low) &&
                     (w_tod >= r_rd.win_begin) && (w_tod <= r_rd.win_end);

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_hit <= 1'b0;
        end else if (r_cmp_vld && w_match) begin
            r_hit <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_granted <= r_hit;
        end
    end

    assign o_sts.mod_last   = (r_step == '0);
    assign o_sts.scan_empty = (w_limit == '0);
    assign o_sts.scan_last  = ((LIM_W'(r_idx) + LIM_W'(1)) == w_limit);
    assign o_granted        = r_granted;

endmodule

// ----- design/access_window_authenticator.sv -----
// Top level of the access window authenticator: controller and datapath.
// Depends on awa_pkg, awa_ctrl and awa_dp.
//
// The block holds a table of MAX_ENTRIES card entries (80-bit UID plus a daily
// window in seconds) and answers each input beat with exactly one result beat.
// A load beat (opcode 0) writes one slot; a slot at or above MAX_ENTRIES is left
// alone and the answer is 0. A query beat (opcode 1) reduces the timestamp modulo
// one day by a reciprocal multiplication, then sweeps the single read port of the
// table one entry per cycle over N entries, N being entry_count clamped to
// MAX_ENTRIES, makes the last compare and hands over the result; when N is 0 it
// skips the sweep and the compare. A stalled earlier answer adds its stall cycles.
// One beat is in work at a time; the input stalls while it is. The
// result register lets a new beat be taken while the previous answer waits.
// Write entry_count only while the block is idle. Table entries have no reset:
// write every slot below entry_count before querying.
module access_window_authenticator
    import awa_pkg::*;
#(
    parameter int MAX_ENTRIES = DEF_MAX_ENTRIES
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // configuration: entry_count
    input  logic              i_cfg_we,
    input  logic [CNT_W-1:0]  i_cfg_wdata,
    // input channel
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic              i_opcode,
    input  logic [SLOT_W-1:0] i_entry_index,
    input  logic [15:0]       i_uid_high,
    input  logic [63:0]       i_uid_low,
    input  logic [4:0]        i_begin_hour,
    input  logic [5:0]        i_begin_minute,
    input  logic [4:0]        i_end_hour,
    input  logic [5:0]        i_end_minute,
    input  logic [TS_W-1:0]   i_timestamp,
    // output channel
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic              o_granted
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    // Sequence each beat: accept, reduce, sweep, hand over.
    awa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_opcode    (i_opcode),
        .i_out_stall (i_out_stall),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid)
    );

    // Hold the table, the reduced time of day and the match flag.
    awa_dp #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_cmd          (w_cmd),
        .i_opcode       (i_opcode),
        .i_entry_index  (i_entry_index),
        .i_uid_high     (i_uid_high),
        .i_uid_low      (i_uid_low),
        .i_begin_hour   (i_begin_hour),
        .i_begin_minute (i_begin_minute),
        .i_end_hour     (i_end_hour),
        .i_end_minute   (i_end_minute),
        .i_timestamp    (i_timestamp),
        .o_sts          (w_sts),
        .o_granted      (o_granted)
    );

endmodule

// ----- design/awa_chk.sv -----
// Port-level checker of the access window authenticator, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module awa_chk (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic o_in_stall,
    input logic o_out_valid,
    input logic i_out_stall,
    input logic o_granted
);

    // Hold a stalled result beat.
    `AWA_ASSERT(a_out_hold, i_clk, i_rst_n, (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_granted)))
    // Go busy after taking a beat.
    `AWA_ASSERT(a_busy_after_accept, i_clk, i_rst_n, (i_in_valid && !o_in_stall) |=> o_in_stall)
    // Leave busy only by placing a result.
    `AWA_ASSERT(a_result_on_idle, i_clk, i_rst_n, ($fell(o_in_stall) && $past(i_rst_n)) |-> o_out_valid)
    // Come out of reset idle and empty.
    `AWA_ASSERT_ALWAYS(a_reset_state, i_clk, !i_rst_n |=> (!o_out_valid && !o_in_stall))

endmodule

bind access_window_authenticator awa_chk u_awa_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_granted   (o_granted)
);

// ----- verif/access_window_authenticator_tb.sv -----
// Self-checking testbench of access_window_authenticator: directed and random load and
// query beats, every grant predicted in the bench and checked in order of arrival.
// Depends on awa_pkg and the RTL of the block only.
module access_window_authenticator_tb
    import awa_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_DEPTH = DEF_MAX_ENTRIES;
    localparam int POOL_SIZE   = 8;
    // Largest whole number of days that leaves room for any time of day in 32 bits.
    localparam int LAST_DAY    = 49709;
    localparam int MAX_REPORTS = 50;

    // Fixed card identities for the directed beats.
    localparam logic [15:0] A_HI = 16'h1234;
    localparam logic [63:0] A_LO = 64'h0123_4567_89AB_CDEF;
    localparam logic [15:0] B_HI = 16'h00B0;
    localparam logic [63:0] B_LO = 64'h8000_0000_0000_0001;
    localparam logic [15:0] C_HI = 16'h7FFE;
    localparam logic [63:0] C_LO = 64'h5A5A_A5A5_5A5A_A5A5;
    localparam logic [15:0] D_HI = 16'hC001;
    localparam logic [63:0] D_LO = 64'h0000_FFFF_0000_FFFF;

    typedef struct {
        logic              opcode;
        logic [SLOT_W-1:0] slot;
        logic [15:0]       uid_high;
        logic [63:0]       uid_low;
        logic [4:0]        begin_hour;
        logic [5:0]        begin_minute;
        logic [4:0]        end_hour;
        logic [5:0]        end_minute;
        logic [TS_W-1:0]   timestamp;
    } t_card_beat;

    // ------------------------------------------------------------------
    // Block ports, all inputs known from time zero
    // ------------------------------------------------------------------
    logic              i_clk          = 1'b0;
    logic              i_rst_n        = 1'b0;
    logic              i_cfg_we       = 1'b0;
    logic [CNT_W-1:0]  i_cfg_wdata    = '0;
    logic              i_in_valid     = 1'b0;
    logic              o_in_stall;
    logic              i_opcode       = OP_LOAD;
    logic [SLOT_W-1:0] i_entry_index  = '0;
    logic [15:0]       i_uid_high     = '0;
    logic [63:0]       i_uid_low      = '0;
    logic [4:0]        i_begin_hour   = '0;
    logic [5:0]        i_begin_minute = '0;
    logic [4:0]        i_end_hour     = '0;
    logic [5:0]        i_end_minute   = '0;
    logic [TS_W-1:0]   i_timestamp    = '0;
    logic              o_out_valid;
    logic              i_out_stall    = 1'b0;
    logic              o_granted;

    access_window_authenticator dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_opcode       (i_opcode),
        .i_entry_index  (i_entry_index),
        .i_uid_high     (i_uid_high),
        .i_uid_low      (i_uid_low),
        .i_begin_hour   (i_begin_hour),
        .i_begin_minute (i_begin_minute),
        .i_end_hour     (i_end_hour),
        .i_end_minute   (i_end_minute),
        .i_timestamp    (i_timestamp),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_granted      (o_granted)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predicted access table: updated as each beat is accepted
    // ------------------------------------------------------------------
    logic [15:0]      acl_uid_high [TABLE_DEPTH];
    logic [63:0]      acl_uid_low  [TABLE_DEPTH];
    logic [TOD_W-1:0] acl_begin    [TABLE_DEPTH];
    logic [TOD_W-1:0] acl_end      [TABLE_DEPTH];
    int               acl_count = 0;

    t_card_beat pending_beats[$];   // beats waiting for the driver
    bit         expected_grants[$]; // one predicted grant per accepted beat

    // Stimulus-side view of the table, used only to aim queries at real windows.
    logic [15:0] stim_uid_high [TABLE_DEPTH];
    logic [63:0] stim_uid_low  [TABLE_DEPTH];
    int          stim_begin    [TABLE_DEPTH];
    int          stim_end      [TABLE_DEPTH];
    logic [15:0] pool_uid_high [POOL_SIZE];
    logic [63:0] pool_uid_low  [POOL_SIZE];

    bit idling_on = 1'b1;
    int n_loads   = 0;
    int n_queries = 0;
    int n_grants  = 0;
    int n_errors  = 0;

    function automatic int win_seconds(input logic [4:0] hour, input logic [5:0] minute);
        return int'(hour) * SEC_PER_HOUR + int'(minute) * SEC_PER_MIN;
    endfunction

    // Apply one accepted beat to the predicted table and return the grant it earns.
    function automatic bit grant_for_beat(input t_card_beat b);
        int tod;
        int lim;
        if (b.opcode == OP_LOAD) begin
            // a slot beyond the table writes nothing
            if (int'(b.slot) < TABLE_DEPTH) begin
                acl_uid_high[b.slot] = b.uid_high;
                acl_uid_low[b.slot]  = b.uid_low;
                acl_begin[b.slot]    = TOD_W'(win_seconds(b.begin_hour, b.begin_minute));
                acl_end[b.slot]      = TOD_W'(win_seconds(b.end_hour, b.end_minute));
            end
            return 1'b0;
        end
        tod = int'(b.timestamp % SEC_PER_DAY);
        // a count above the table size searches the whole table
        lim = (acl_count > TABLE_DEPTH) ? TABLE_DEPTH : acl_count;
        for (int i = 0; i < lim; i++) begin
            // bounds inclusive; an inverted window can never hold tod
            if (acl_uid_high[i] == b.uid_high && acl_uid_low[i] == b.uid_low &&
                tod >= int'(acl_begin[i]) && tod <= int'(acl_end[i]))
                return 1'b1;
        end
        return 1'b0;
    endfunction

    // Mostly back to back, sometimes a short pause, now and then a long one; always back to back while idling is off.
    function automatic int pick_gap();
        int r;
        if (!idling_on)
            return 0;
        r = $urandom_range(99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(3, 1);
        if (r < 97)
            return $urandom_range(12, 4);
        return $urandom_range(60, 20);
    endfunction

    // ------------------------------------------------------------------
    // Driver: present queued beats, hold the payload while stalled
    // ------------------------------------------------------------------
    t_card_beat on_wire;
    int         send_gap = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            // predict on the beat the block has just taken
            if (i_in_valid && !o_in_stall) begin
                expected_grants.push_back(grant_for_beat(on_wire));
                if (on_wire.opcode == OP_LOAD)
                    n_loads++;
                else
                    n_queries++;
            end
            if (!i_in_valid || !o_in_stall) begin
                if (send_gap > 0 || pending_beats.size() == 0) begin
                    if (send_gap > 0)
                        send_gap--;
                    i_in_valid <= 1'b0;
                end else begin
                    on_wire = pending_beats.pop_front();
                    i_opcode       <= on_wire.opcode;
                    i_entry_index  <= on_wire.slot;
                    i_uid_high     <= on_wire.uid_high;
                    i_uid_low      <= on_wire.uid_low;
                    i_begin_hour   <= on_wire.begin_hour;
                    i_begin_minute <= on_wire.begin_minute;
                    i_end_hour     <= on_wire.end_hour;
                    i_end_minute   <= on_wire.end_minute;
                    i_timestamp    <= on_wire.timestamp;
                    i_in_valid     <= 1'b1;
                    send_gap = pick_gap();
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: check each result beat against the oldest prediction,
    // and stall the result channel in random bursts
    // ------------------------------------------------------------------
    int stall_left = 0;
    bit grant_due;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_grants.size() == 0) begin
                    n_errors++;
                    if (n_errors <= MAX_REPORTS)
                        $display("%0t: result beat with none predicted, expected none, got %b",
                                 $time, o_granted);
                end else begin
                    grant_due = expected_grants.pop_front();
                    if (grant_due)
                        n_grants++;
                    if (o_granted !== grant_due) begin
                        n_errors++;
                        if (n_errors <= MAX_REPORTS)
                            $display("%0t: granted expected %b, got %b",
                                     $time, grant_due, o_granted);
                    end
                end
                if (n_errors == MAX_REPORTS + 1)
                    $display("%0t: further mismatch reports suppressed", $time);
            end
            if (stall_left > 0) begin
                stall_left--;
                i_out_stall <= 1'b1;
            end else begin
                stall_left = pick_gap();
                i_out_stall <= (stall_left > 0);
                if (stall_left > 0)
                    stall_left--;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic wait_drained();
        while (pending_beats.size() != 0 || i_in_valid || expected_grants.size() != 0)
            @(posedge i_clk);
    endtask

    // Write entry_count only once the block has answered everything sent so far.
    task automatic set_entry_count(input int value);
        wait_drained();
        repeat (3) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= CNT_W'(value);
        @(posedge i_clk);
        acl_count = value;
        i_cfg_we <= 1'b0;
    endtask

    task automatic queue_load(input logic [4:0] slot, input logic [15:0] uh,
                              input logic [63:0] ul, input logic [4:0] bh,
                              input logic [5:0] bm, input logic [4:0] eh,
                              input logic [5:0] em);
        t_card_beat b;
        b.opcode       = OP_LOAD;
        b.slot         = slot;
        b.uid_high     = uh;
        b.uid_low      = ul;
        b.begin_hour   = bh;
        b.begin_minute = bm;
        b.end_hour     = eh;
        b.end_minute   = em;
        b.timestamp    = $urandom();    // ignored by a load
        pending_beats.push_back(b);
        stim_uid_high[slot] = uh;
        stim_uid_low[slot]  = ul;
        stim_begin[slot]    = win_seconds(bh, bm);
        stim_end[slot]      = win_seconds(eh, em);
    endtask

    task automatic queue_query(input logic [15:0] uh, input logic [63:0] ul,
                               input logic [31:0] ts);
        t_card_beat b;
        b.opcode       = OP_QUERY;
        // slot and window fields are ignored by a query: fill with noise
        b.slot         = SLOT_W'($urandom());
        b.begin_hour   = 5'($urandom());
        b.begin_minute = 6'($urandom());
        b.end_hour     = 5'($urandom());
        b.end_minute   = 6'($urandom());
        b.uid_high     = uh;
        b.uid_low      = ul;
        b.timestamp    = ts;
        pending_beats.push_back(b);
    endtask

    // Place a time of day on a random day, often day zero.
    function automatic logic [31:0] stamp_at(input int tod);
        longint days;
        days = ($urandom_range(9) < 4) ? 0 : $urandom_range(LAST_DAY);
        return 32'(days * SEC_PER_DAY + tod);
    endfunction

    task automatic queue_random_load(input logic [4:0] slot);
        int          pick;
        int          start_min;
        int          stop_min;
        logic [15:0] uh;
        logic [63:0] ul;
        logic [4:0]  bh;
        logic [5:0]  bm;
        logic [4:0]  eh;
        logic [5:0]  em;
        pick = $urandom_range(POOL_SIZE - 1);
        if ($urandom_range(9) < 7) begin
            uh = pool_uid_high[pick];
            ul = pool_uid_low[pick];
        end else begin
            uh = 16'($urandom());
            ul = {$urandom(), $urandom()};
        end
        if ($urandom_range(99) < 15) begin
            // raw hour and minute fields, out of range ones included
            bh = 5'($urandom());
            bm = 6'($urandom());
            eh = 5'($urandom());
            em = 6'($urandom());
        end else begin
            start_min = $urandom_range(1439);
            if ($urandom_range(3) != 0) begin
                stop_min = start_min + $urandom_range(600);
                if (stop_min > 1439)
                    stop_min = 1439;
            end else begin
                stop_min = $urandom_range(1439);   // may well be inverted
            end
            bh = 5'(start_min / 60);
            bm = 6'(start_min % 60);
            eh = 5'(stop_min / 60);
            em = 6'(stop_min % 60);
        end
        queue_load(slot, uh, ul, bh, bm, eh, em);
    endtask

    // Aim most queries at a searched entry, on or just off its window bounds, inside it or anywhere in the day.
    task automatic queue_random_query(input int lim);
        int          s;
        int          tod;
        int          pick;
        logic [15:0] uh;
        logic [63:0] ul;
        logic [31:0] ts;
        tod = $urandom_range(SEC_PER_DAY - 1);
        if (lim > 0 && $urandom_range(9) < 7) begin
            s  = $urandom_range(lim - 1);
            uh = stim_uid_high[s];
            ul = stim_uid_low[s];
            case ($urandom_range(5))
                0: tod = stim_begin[s];
                1: tod = stim_end[s];
                2: tod = stim_begin[s] - 1;
                3: tod = stim_end[s] + 1;
                4: begin
                    if (stim_begin[s] <= stim_end[s])
                        tod = $urandom_range(stim_end[s], stim_begin[s]);
                end
                default: ;
            endcase
            if (tod < 0 || tod >= SEC_PER_DAY)
                tod = $urandom_range(SEC_PER_DAY - 1);
        end else if ($urandom_range(1) == 0) begin
            pick = $urandom_range(POOL_SIZE - 1);
            uh   = pool_uid_high[pick];
            ul   = pool_uid_low[pick];
        end else begin
            uh = 16'($urandom());
            ul = {$urandom(), $urandom()};
        end
        ts = ($urandom_range(9) == 0) ? $urandom() : stamp_at(tod);
        queue_query(uh, ul, ts);
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    int phase_counts[10] = '{32, 63, 1, 0, 33, 17, 63, 2, 32, 0};
    int phase_count;

    initial begin
        for (int i = 0; i < POOL_SIZE; i++) begin
            pool_uid_high[i] = 16'($urandom());
            pool_uid_low[i]  = {$urandom(), $urandom()};
        end

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Empty search: nothing may be granted, whatever the card.
        set_entry_count(0);
        queue_query(16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF, 32'd0);
        queue_query(A_HI, A_LO, 32'hFFFF_FFFF);

        // Directed table: full day, out-of-range window, shared UIDs, inverted window,
        // one-second windows and the top slot.
        queue_load(5'd0, 16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF, 5'd0, 6'd0, 5'd23, 6'd59);
        queue_load(5'd1, 16'h0000, 64'h0, 5'd31, 6'd63, 5'd31, 6'd63);
        queue_load(5'd2, A_HI, A_LO, 5'd8, 6'd30, 5'd17, 6'd15);
        queue_load(5'd3, A_HI, A_LO, 5'd20, 6'd0, 5'd6, 6'd0);
        queue_load(5'd4, B_HI, B_LO, 5'd23, 6'd59, 5'd23, 6'd59);
        queue_load(5'd5, A_HI, A_LO ^ 64'h1, 5'd0, 6'd0, 5'd23, 6'd59);
        queue_load(5'd6, D_HI, D_LO, 5'd12, 6'd0, 5'd12, 6'd0);
        queue_load(5'd7, D_HI, D_LO, 5'd0, 6'd0, 5'd0, 6'd0);
        queue_load(5'd31, C_HI, C_LO, 5'd0, 6'd0, 5'd0, 6'd0);

        set_entry_count(8);
        queue_query(A_HI, A_LO, 32'd30600);                     // on the opening bound
        queue_query(A_HI, A_LO, 32'd30599);                     // one second early
        queue_query(A_HI, A_LO, 32'd62100);                     // on the closing bound
        queue_query(A_HI, A_LO, 32'd62101);                     // one second late
        queue_query(A_HI, A_LO, 32'd4_233_630_600);             // same day time, far later
        queue_query(A_HI, A_LO, 32'd75600);                     // only the inverted window
        queue_query(A_HI, A_LO ^ 64'h1, 32'd75600);             // low half differs
        queue_query(A_HI ^ 16'h8000, A_LO, 32'd40000);          // high half differs
        queue_query(16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF);
        queue_query(16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF, 32'd86399);
        queue_query(16'h0000, 64'h0, 32'd0);                    // window beyond the day
        queue_query(B_HI, B_LO, 32'd86340);
        queue_query(C_HI, C_LO, 32'd0);                         // top slot not yet searched
        queue_query(D_HI, D_LO, 32'd43200);

        // Fill the rest of the table so that any entry_count may be searched.
        for (int s = 8; s < TABLE_DEPTH - 1; s++)
            queue_random_load(5'(s));
        repeat (40) begin
            if ($urandom_range(3) == 0)
                queue_random_load(5'($urandom()));
            else
                queue_random_query(8);
        end

        // Random phases; each entry_count change drains the block first, so the sender
        // pauses until every predicted result has come back.
        for (int p = 0; p < 10; p++) begin
            phase_count = (p == 9) ? $urandom_range(63) : phase_counts[p];
            set_entry_count(phase_count);
            idling_on = (p != 1 && p != 5);
            if (p == 0)
                queue_query(C_HI, C_LO, 32'd0);                 // top slot now searched
            repeat (168) begin
                if ($urandom_range(3) == 0)
                    queue_random_load(5'($urandom()));
                else
                    queue_random_query((phase_count > TABLE_DEPTH) ? TABLE_DEPTH
                                                                   : phase_count);
            end
        end

        wait_drained();
        repeat (60) @(posedge i_clk);

        $display("Run covered %0d table loads and %0d card queries, %0d of them granted,",
                 n_loads, n_queries, n_grants);
        $display("with entry_count swept from 0 through 32 up to 63, clamping included.");
        if (n_errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #20_000_000;
        $display("Run timed out with %0d predictions outstanding", expected_grants.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ----- access_window_authenticator.f -----
+incdir+design
design/awa_pkg.sv
design/awa_ctrl.sv
design/awa_dp.sv
design/access_window_authenticator.sv
design/awa_chk.sv
verif/access_window_authenticator_tb.sv
